@@ hdl/grid_cell_pareto_dominance_core_macros.svh @@
// Assertion macros for the grid cell Pareto dominance core.
// Included by the checker module; expects clk_i and rst_ni in scope.
`ifndef GRID_CELL_PARETO_DOMINANCE_CORE_MACROS_SVH
`define GRID_CELL_PARETO_DOMINANCE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gcpd_pkg.sv @@
// Shared types, constants and codes for the grid cell Pareto dominance core.
// No dependencies; imported by every module of the block.
package gcpd_pkg;

  localparam int MAX_OBJECTIVES  = 8;
  localparam int INDEX_WIDTH     = 32;
  localparam int STEP_BITS       = 8;
  localparam int STEPS_PER_DIGIT = (INDEX_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W           = STEPS_PER_DIGIT * STEP_BITS;
  localparam int NUM_DIGITS      = MAX_OBJECTIVES - 1;
  localparam int NUM_CELLS       = NUM_DIGITS * STEPS_PER_DIGIT;

  localparam int CNT_W      = 4;
  localparam int RADIX_W    = 8;
  localparam int REM_W      = RADIX_W;
  localparam int ACT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int REL_W      = 3;

  localparam logic [CNT_W-1:0]   OBJ_COUNT_RESET = CNT_W'(2);
  localparam logic [RADIX_W-1:0] DIVISIONS_RESET = RADIX_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJ_COUNT = 2'd0,
    REG_DIVISIONS = 2'd1
  } gcpd_cfg_reg_e;

  typedef enum logic [REL_W-1:0] {
    REL_NONDOM    = 3'd0,
    REL_A_STRICT  = 3'd1,
    REL_A_WEAK    = 3'd2,
    REL_B_STRICT  = 3'd3,
    REL_B_WEAK    = 3'd4,
    REL_IDENTICAL = 3'd5
  } gcpd_rel_e;

  typedef struct packed {
    logic               same;
    logic [DIV_W-1:0]   qa;
    logic [DIV_W-1:0]   qb;
    logic [REM_W-1:0]   ra;
    logic [REM_W-1:0]   rb;
    logic               a_better;
    logic               b_better;
    logic               any_equal;
  } gcpd_item_t;

  typedef struct packed {
    logic               div_en;
    logic               digit_start;
    logic               fold_en;
    logic [RADIX_W-1:0] radix;
  } gcpd_cell_ctrl_t;

endpackage

@@ hdl/gcpd_cell.sv @@
// One cell of the digit extraction chain: eight restoring division steps on
// both indices, with an optional fold of the previous digit. Uses gcpd_pkg.
module gcpd_cell
  import gcpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gcpd_cell_ctrl_t ctrl_i,
  input  logic            prev_valid_i,
  input  gcpd_item_t      prev_item_i,
  output logic            take_o,
  input  logic            next_take_i,
  output logic            valid_o,
  output gcpd_item_t      item_o
);

  logic       valid_q;
  gcpd_item_t item_q;
  gcpd_item_t item_d;

  assign take_o  = !valid_q || next_take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    logic [DIV_W-1:0] qa;
    logic [DIV_W-1:0] qb;
    logic [REM_W-1:0] ra;
    logic [REM_W-1:0] rb;
    logic [REM_W:0]   ta;
    logic [REM_W:0]   tb;
    logic [REM_W:0]   div_ext;
    item_d  = prev_item_i;
    div_ext = {1'b0, ctrl_i.radix};
    if (ctrl_i.fold_en) begin
      item_d.a_better  = prev_item_i.a_better  || (prev_item_i.ra < prev_item_i.rb);
      item_d.b_better  = prev_item_i.b_better  || (prev_item_i.ra > prev_item_i.rb);
      item_d.any_equal = prev_item_i.any_equal || (prev_item_i.ra == prev_item_i.rb);
    end
    qa = prev_item_i.qa;
    qb = prev_item_i.qb;
    ra = ctrl_i.digit_start ? '0 : prev_item_i.ra;
    rb = ctrl_i.digit_start ? '0 : prev_item_i.rb;
    for (int s = 0; s < STEP_BITS; s++) begin
      ta = {ra, qa[DIV_W-1]};
      tb = {rb, qb[DIV_W-1]};
      qa = {qa[DIV_W-2:0], 1'b0};
      qb = {qb[DIV_W-2:0], 1'b0};
      if (ta >= div_ext) begin
        ta    = ta - div_ext;
        qa[0] = 1'b1;
      end
      if (tb >= div_ext) begin
        tb    = tb - div_ext;
        qb[0] = 1'b1;
      end
      ra = ta[REM_W-1:0];
      rb = tb[REM_W-1:0];
    end
    if (ctrl_i.div_en) begin
      item_d.qa = qa;
      item_d.qb = qb;
      item_d.ra = ra;
      item_d.rb = rb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && prev_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

@@ hdl/gcpd_out_stage.sv @@
// Output stage: folds the last digit and the leading coordinate, encodes the
// relation and holds it in the output register. Uses gcpd_pkg.
module gcpd_out_stage
  import gcpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fold_en_i,
  input  logic             prev_valid_i,
  input  gcpd_item_t       prev_item_i,
  output logic             take_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [REL_W-1:0] relation_o
);

  logic             valid_q;
  logic [REL_W-1:0] relation_q;
  logic [REL_W-1:0] relation_d;

  assign take_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign relation_o  = relation_q;

  always_comb begin
    logic a_better;
    logic b_better;
    logic any_equal;
    a_better  = prev_item_i.a_better;
    b_better  = prev_item_i.b_better;
    any_equal = prev_item_i.any_equal;
    if (fold_en_i) begin
      a_better  = a_better  || (prev_item_i.ra < prev_item_i.rb);
      b_better  = b_better  || (prev_item_i.ra > prev_item_i.rb);
      any_equal = any_equal || (prev_item_i.ra == prev_item_i.rb);
    end
    a_better  = a_better  || (prev_item_i.qa < prev_item_i.qb);
    b_better  = b_better  || (prev_item_i.qa > prev_item_i.qb);
    any_equal = any_equal || (prev_item_i.qa == prev_item_i.qb);
    if (prev_item_i.same) begin
      relation_d = REL_IDENTICAL;
    end else if (a_better && b_better) begin
      relation_d = REL_NONDOM;
    end else if (a_better) begin
      relation_d = any_equal ? REL_A_WEAK : REL_A_STRICT;
    end else begin
      relation_d = any_equal ? REL_B_WEAK : REL_B_STRICT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && prev_valid_i) begin
      relation_q <= relation_d;
    end
  end

endmodule

@@ hdl/grid_cell_pareto_dominance_core.sv @@
// Top level of the grid cell Pareto dominance core: configuration registers,
// the chain of division cells and the output stage. Uses gcpd_pkg, gcpd_cell
// and gcpd_out_stage.
//
// Usage: a pair of cell indices is transferred on the input channel
// (in_valid_i, in_stall_o, index_a_i, index_b_i) and one relation code comes
// back on the output channel (out_valid_o, out_stall_i, relation_o).
// The block accepts one pair per cycle while in_stall_o is low and returns
// results in order. A transfer loads the first of 28 cells (seven digit
// extractions of four cells each, every cell doing eight bits of a restoring
// division on both indices); the pair then passes each further cell and the
// output register in turn before out_valid_o rises.
// Every stage moves on when its successor has room, so a stalled receiver
// only stops the input once all stages hold items; bubbles are squeezed out.
// The result register holds its value while out_stall_i is high.
// Reset clears all valid bits and loads objective_count = 2 and
// divisions = 10. Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i)
// take effect at once and must only be issued while the block is empty.
module grid_cell_pareto_dominance_core
  import gcpd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [INDEX_WIDTH-1:0] index_a_i,
  input  logic [INDEX_WIDTH-1:0] index_b_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [REL_W-1:0]       relation_o
);

  logic [CNT_W-1:0]      obj_count_q;
  logic [RADIX_W-1:0]    divisions_q;
  logic [RADIX_W-1:0]    radix;
  logic [NUM_DIGITS-1:0] digit_active;
  logic [NUM_CELLS:0]    stage_valid;
  logic [NUM_CELLS:0]    stage_take;
  gcpd_item_t            stage_item [NUM_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_count_q <= OBJ_COUNT_RESET;
      divisions_q <= DIVISIONS_RESET;
    end else if (cfg_we_i) begin
      case (gcpd_cfg_reg_e'(cfg_idx_i))
        REG_OBJ_COUNT: obj_count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_DIVISIONS: divisions_q <= cfg_wdata_i[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign radix = (divisions_q == '0) ? RADIX_W'(1) : divisions_q;

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_active
    assign digit_active[k] = ACT_W'(obj_count_q) > ACT_W'(k + 1);
  end

  always_comb begin
    stage_item[0]           = '0;
    stage_item[0].same      = (index_a_i == index_b_i);
    stage_item[0].qa        = DIV_W'(index_a_i);
    stage_item[0].qb        = DIV_W'(index_b_i);
  end

  assign stage_valid[0] = in_valid_i;
  assign in_stall_o     = !stage_take[0];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gcpd_cell_ctrl_t ctrl;
    assign ctrl.div_en      = digit_active[i / STEPS_PER_DIGIT];
    assign ctrl.digit_start = ((i % STEPS_PER_DIGIT) == 0);
    assign ctrl.radix       = radix;
    if (((i % STEPS_PER_DIGIT) == 0) && (i >= STEPS_PER_DIGIT)) begin : g_fold
      assign ctrl.fold_en = digit_active[i / STEPS_PER_DIGIT - 1];
    end else begin : g_nofold
      assign ctrl.fold_en = 1'b0;
    end

    gcpd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (stage_valid[i]),
      .prev_item_i  (stage_item[i]),
      .take_o       (stage_take[i]),
      .next_take_i  (stage_take[i+1]),
      .valid_o      (stage_valid[i+1]),
      .item_o       (stage_item[i+1])
    );
  end

  gcpd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fold_en_i    (digit_active[NUM_DIGITS-1]),
    .prev_valid_i (stage_valid[NUM_CELLS]),
    .prev_item_i  (stage_item[NUM_CELLS]),
    .take_o       (stage_take[NUM_CELLS]),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .relation_o   (relation_o)
  );

endmodule

@@ hdl/grid_cell_pareto_dominance_core_chk.sv @@
// Port-level checker for the grid cell Pareto dominance core, bound to the
// top level. Uses gcpd_pkg and grid_cell_pareto_dominance_core_macros.svh.
`include "grid_cell_pareto_dominance_core_macros.svh"

module grid_cell_pareto_dominance_core_chk
  import gcpd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [REL_W-1:0]       relation_o
);

  `GCPD_ASSERT_NOW(a_no_stall_when_drained, (!out_valid_o || !out_stall_i), !in_stall_o, "input stalled although the output can take a transfer")
  `GCPD_ASSERT_NOW(a_relation_code_legal, out_valid_o, (relation_o <= REL_W'(REL_IDENTICAL)), "relation code out of range")
  `GCPD_ASSERT_NEXT(a_result_held, (out_valid_o && out_stall_i), (out_valid_o && $stable(relation_o)), "stalled result changed")

endmodule

bind grid_cell_pareto_dominance_core grid_cell_pareto_dominance_core_chk u_chk (.*);

@@ sim/grid_cell_pareto_dominance_core_tb.sv @@
// Testbench for grid_cell_pareto_dominance_core: queued index pairs under several grid settings,
// with random idling on both channels. Each relation is checked against an in-bench predictor.
// Depends on gcpd_pkg and the core RTL only.
`timescale 1ns / 1ps

module grid_cell_pareto_dominance_core_tb;
  import gcpd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PAIRS_PER_PHASE = 130;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] a;
    logic [INDEX_WIDTH-1:0] b;
  } index_pair_t;

  typedef enum int {
    MOVE_SAME,
    MOVE_UP,
    MOVE_DOWN
  } digit_move_e;

  typedef enum int {
    SHAPE_B_WORSE,
    SHAPE_B_BETTER,
    SHAPE_MIXED,
    SHAPE_STRICT
  } pair_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [INDEX_WIDTH-1:0] index_a_i = '0;
  logic [INDEX_WIDTH-1:0] index_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [REL_W-1:0] relation_o;

  logic [CNT_W-1:0] objective_count_q = OBJ_COUNT_RESET;
  logic [RADIX_W-1:0] divisions_q = DIVISIONS_RESET;

  index_pair_t pending_pairs[$];
  gcpd_rel_e expected_relations[$];
  int pairs_queued = 0;
  int pairs_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_wait = 0;
  int take_wait = 0;
  logic send_burst = 1'b0;
  logic take_burst = 1'b0;

  grid_cell_pareto_dominance_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .relation_o  (relation_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int active_objectives();
    if (objective_count_q == '0) return 1;
    if (objective_count_q > MAX_OBJECTIVES) return MAX_OBJECTIVES;
    return int'(objective_count_q);
  endfunction

  function automatic int active_radix();
    return (divisions_q == '0) ? 1 : int'(divisions_q);
  endfunction

  function automatic gcpd_rel_e predict_relation(input logic [INDEX_WIDTH-1:0] a,
                                                 input logic [INDEX_WIDTH-1:0] b);
    logic [INDEX_WIDTH-1:0] rest_a, rest_b, digit_a, digit_b, radix;
    logic a_better, b_better, any_equal;
    int n;
    if (a == b) return REL_IDENTICAL;
    n = active_objectives();
    radix = INDEX_WIDTH'(active_radix());
    rest_a = a;
    rest_b = b;
    a_better = 1'b0;
    b_better = 1'b0;
    any_equal = 1'b0;
    for (int j = n - 1; j >= 0; j--) begin
      if (j > 0) begin
        digit_a = rest_a % radix;
        digit_b = rest_b % radix;
        rest_a = rest_a / radix;
        rest_b = rest_b / radix;
      end else begin
        digit_a = rest_a;
        digit_b = rest_b;
      end
      if (digit_a < digit_b) a_better = 1'b1;
      else if (digit_a > digit_b) b_better = 1'b1;
      else any_equal = 1'b1;
    end
    if (a_better && b_better) return REL_NONDOM;
    if (a_better) return any_equal ? REL_A_WEAK : REL_A_STRICT;
    return any_equal ? REL_B_WEAK : REL_B_STRICT;
  endfunction

  // Most pairs are built digit by digit from the current grid so that equal
  // and one-sided coordinates, and thus the weak and strict cases, come up often.
  function automatic index_pair_t random_pair();
    index_pair_t pair;
    longint unsigned digits_a [MAX_OBJECTIVES];
    longint unsigned digits_b [MAX_OBJECTIVES];
    longint unsigned rest, radix, encoded;
    int n, roll;
    logic up_only;
    pair_shape_e shape;
    digit_move_e move;
    n = active_objectives();
    radix = longint'(active_radix());
    pair.a = $urandom() >> $urandom_range(0, INDEX_WIDTH - 1);
    roll = $urandom_range(0, 19);
    if (roll < 3) begin
      pair.a = $urandom();
      pair.b = $urandom();
      return pair;
    end
    if (roll == 3) begin
      pair.b = pair.a;
      return pair;
    end
    rest = pair.a;
    for (int j = n - 1; j > 0; j--) begin
      digits_a[j] = rest % radix;
      rest = rest / radix;
    end
    digits_a[0] = rest;
    shape = pair_shape_e'($urandom_range(0, SHAPE_STRICT));
    up_only = 1'($urandom_range(0, 1));
    encoded = 0;
    for (int j = 0; j < n; j++) begin
      case (shape)
        SHAPE_B_WORSE:  move = $urandom_range(0, 1) ? MOVE_UP : MOVE_SAME;
        SHAPE_B_BETTER: move = $urandom_range(0, 1) ? MOVE_DOWN : MOVE_SAME;
        SHAPE_MIXED:    move = digit_move_e'($urandom_range(0, MOVE_DOWN));
        default:        move = up_only ? MOVE_UP : MOVE_DOWN;
      endcase
      digits_b[j] = digits_a[j];
      if (move == MOVE_UP && j == 0)
        digits_b[j] = digits_a[j] + $urandom_range(1, 3);
      else if (move == MOVE_UP && digits_a[j] + 1 < radix)
        digits_b[j] = $urandom_range(32'(radix - 1), 32'(digits_a[j] + 1));
      else if (move == MOVE_DOWN && digits_a[j] > 0)
        digits_b[j] = $urandom_range(0, 32'(digits_a[j] - 1));
      encoded = encoded * radix + digits_b[j];
    end
    pair.b = encoded[INDEX_WIDTH-1:0];
    return pair;
  endfunction

  function automatic int draw_wait(input logic burst);
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic queue_pair(input index_pair_t pair);
    pending_pairs.push_back(pair);
    pairs_queued++;
  endtask

  task automatic wait_idle();
    while (pairs_accepted != pairs_queued || expected_relations.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_OBJ_COUNT: objective_count_q = data[CNT_W-1:0];
      REG_DIVISIONS: divisions_q = data[RADIX_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] count_data,
                           input logic [CFG_DATA_W-1:0] divisions_data);
    write_register(REG_OBJ_COUNT, count_data);
    write_register(REG_DIVISIONS, divisions_data);
    write_register(REG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
    repeat (PAIRS_PER_PHASE) queue_pair(random_pair());
    wait_idle();
  endtask

  // Input side: one pair per transfer, held steady while stalled.
  always @(posedge clk_i) begin
    logic hold;
    index_pair_t next_pair;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      hold = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_relations.push_back(predict_relation(index_a_i, index_b_i));
        pairs_accepted++;
        hold = 1'b0;
        send_wait = draw_wait(send_burst);
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
      end
      if (!hold) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_pairs.size() != 0) begin
          next_pair = pending_pairs.pop_front();
          index_a_i <= next_pair.a;
          index_b_i <= next_pair.b;
          hold = 1'b1;
        end
      end
      in_valid_i <= hold;
    end
  end

  // Output side: checks every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    gcpd_rel_e want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_relations.size() == 0) begin
          $display("%0t: relation mismatch, expected none, actual %0d", $time, relation_o);
          mismatches++;
        end else begin
          want = expected_relations.pop_front();
          if (relation_o !== want) begin
            $display("%0t: relation mismatch, expected %0d, actual %0d",
                     $time, want, relation_o);
            mismatches++;
          end
        end
        take_wait = draw_wait(take_burst);
        if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_stall_i <= (take_wait > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_cell_pareto_dominance_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_pair(index_pair_t'{32'h0000_0000, 32'h0000_0000});
    queue_pair(index_pair_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    queue_pair(index_pair_t'{32'h0000_0000, 32'hFFFF_FFFF});
    queue_pair(index_pair_t'{32'hFFFF_FFFF, 32'h0000_0000});
    queue_pair(index_pair_t'{32'd12, 32'd34});
    queue_pair(index_pair_t'{32'd13, 32'd33});
    queue_pair(index_pair_t'{32'd34, 32'd12});
    queue_pair(index_pair_t'{32'd33, 32'd13});
    queue_pair(index_pair_t'{32'd19, 32'd31});
    queue_pair(index_pair_t'{32'd10, 32'd0});
    queue_pair(index_pair_t'{32'h5555_5555, 32'hAAAA_AAAA});
    queue_pair(index_pair_t'{32'hAAAA_AAAA, 32'h5555_5555});
    repeat (PAIRS_PER_PHASE) queue_pair(random_pair());
    wait_idle();

    run_phase(8'h01, 8'd10);
    run_phase(8'h08, 8'd255);
    run_phase(8'h00, 8'd7);
    run_phase(8'hF9, 8'd0);
    run_phase(8'h03, 8'd1);
    run_phase(8'h08, 8'd2);
    run_phase(8'h0F, 8'hFF);
    run_phase(8'h04, 8'd16);
    for (int k = 0; k < 6; k++) begin
      run_phase(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("grid_cell_pareto_dominance_core verification clean");
    end else begin
      $display("grid_cell_pareto_dominance_core verification failed");
    end
    $finish;
  end

endmodule
